### rtl/cse_pkg.sv
// Shared types, opcodes and sizes for the CAN signal extract/insert block.
package cse_pkg;

  localparam int FRAME_BYTES_DEF = 8;
  // Signals reach at most frame byte 15; byte access reaches byte 7.
  localparam int WIN_BYTES_MAX = 16;
  localparam int OFF_W = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_WR_BYTE = 2'd0;
  localparam logic [1:0] OP_RD_BYTE = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;
  localparam logic [1:0] OP_INSERT  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  byte_index;
    logic [7:0]  byte_data;
    logic [5:0]  start_bit;
    logic [6:0]  bit_length;
    logic        is_signed;
    logic        big_endian;
    logic [63:0] signal_in;
  } in_t;

  typedef struct packed {
    logic [63:0] signal_value;
    logic [7:0]  byte_out;
    logic        range_error;
  } out_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       byte_index;
    logic [7:0]       byte_data;
    logic [OFF_W-1:0] offset;
    logic [6:0]       bit_length;
    logic             is_signed;
    logic             big_endian;
    logic             range_error;
    logic [63:0]      signal_in;
  } cmd_t;

endpackage

### rtl/cse_front.sv
// Front end: classifies an item, checks range and maps it to a window bit offset.
module cse_front import cse_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  in_t  item,
  output cmd_t cmd
);

  localparam int WIN_BYTES = (FRAME_BYTES < WIN_BYTES_MAX) ? FRAME_BYTES : WIN_BYTES_MAX;
  localparam logic [7:0] WIN_BITS = 8'(WIN_BYTES * 8);

  logic [5:0] moto_msb;
  logic [7:0] first_pos;
  logic [7:0] last_pos;
  logic [7:0] moto_off;
  logic       len_ok;
  logic       fits;

  always_comb begin
    moto_msb  = {item.start_bit[5:3], ~item.start_bit[2:0]};
    first_pos = item.big_endian ? {2'b00, moto_msb} : {2'b00, item.start_bit};
    last_pos  = first_pos + {1'b0, item.bit_length} - 8'd1;
    len_ok    = (item.bit_length != 7'd0) && (item.bit_length <= 7'd64);
    fits      = len_ok && (last_pos < WIN_BITS);
    // Motorola runs as Intel order on the byte-reversed window
    moto_off  = WIN_BITS - first_pos - {1'b0, item.bit_length};

    cmd.opcode      = item.opcode;
    cmd.byte_index  = item.byte_index;
    cmd.byte_data   = item.byte_data;
    cmd.offset      = item.big_endian ? moto_off[OFF_W-1:0] : {1'b0, item.start_bit};
    cmd.bit_length  = item.bit_length;
    cmd.is_signed   = item.is_signed;
    cmd.big_endian  = item.big_endian;
    cmd.range_error = ((item.opcode == OP_EXTRACT) || (item.opcode == OP_INSERT)) && !fits;
    cmd.signal_in   = item.signal_in;
  end

endmodule

### rtl/cse_queue.sv
// Small FIFO between the front end and the execution unit.
module cse_queue import cse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  cmd_t       mem [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'(QUEUE_DEPTH));
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/cse_back.sv
// Execution unit: holds the frame window and runs byte access, extract and insert.
module cse_back import cse_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  input  cmd_t cmd,
  output logic done,
  output out_t result
);

  localparam int WIN_BYTES = (FRAME_BYTES < WIN_BYTES_MAX) ? FRAME_BYTES : WIN_BYTES_MAX;
  localparam int W = WIN_BYTES * 8;

  logic [W-1:0] frame;
  logic [W-1:0] frame_next;
  logic [W-1:0] view;
  logic [W-1:0] view_ins;
  logic [W-1:0] shifted;
  logic [W-1:0] ins_mask;
  logic [W-1:0] ins_val;
  logic [63:0]  len_mask;
  logic [63:0]  raw;
  logic [63:0]  value;
  logic         full_len;
  out_t         result_next;

  function automatic logic [W-1:0] byte_rev(input logic [W-1:0] v);
    logic [W-1:0] r;
    for (int i = 0; i < WIN_BYTES; i++) begin
      r[i*8 +: 8] = v[(WIN_BYTES-1-i)*8 +: 8];
    end
    return r;
  endfunction

  always_comb begin
    full_len = (cmd.bit_length == 7'd64);
    len_mask = full_len ? '1 : ((64'd1 << cmd.bit_length[5:0]) - 64'd1);
    view     = cmd.big_endian ? byte_rev(frame) : frame;
    shifted  = view >> cmd.offset;
    raw      = shifted[63:0] & len_mask;
    value    = raw;
    if (cmd.is_signed && !full_len && raw[6'(cmd.bit_length - 7'd1)]) begin
      value = raw | ~len_mask;
    end
    ins_mask = W'(len_mask) << cmd.offset;
    ins_val  = W'(cmd.signal_in & len_mask) << cmd.offset;
    view_ins = (view & ~ins_mask) | ins_val;

    frame_next  = frame;
    result_next = '0;
    unique case (cmd.opcode)
      OP_WR_BYTE: frame_next[{cmd.byte_index, 3'b000} +: 8] = cmd.byte_data;
      OP_RD_BYTE: result_next.byte_out = frame[{cmd.byte_index, 3'b000} +: 8];
      OP_EXTRACT: begin
        result_next.range_error = cmd.range_error;
        if (!cmd.range_error) begin
          result_next.signal_value = value;
        end
      end
      OP_INSERT: begin
        result_next.range_error = cmd.range_error;
        if (!cmd.range_error) begin
          frame_next = cmd.big_endian ? byte_rev(view_ins) : view_ins;
        end
      end
      default: frame_next = frame;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
      done  <= 1'b0;
    end else begin
      done <= valid;
      if (valid) begin
        frame <= frame_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid) begin
      result <= result_next;
    end
  end

endmodule

### rtl/can_signal_extract_insert.sv
// Top level of the CAN frame signal extract/insert block.
//
//   channel  ports                 handshake
//   input    start, busy, cmd      item taken at clk edge with start && !busy
//   result   done, result          one-cycle strobe, taken at the next edge
//
// Each item is written into the FIFO, then the back end registers its result;
// one item per cycle sustained, set by the shift/mask execution stage.
// The front end classifies into a two-entry FIFO that the back end drains every
// cycle, so busy only rises if the FIFO fills. Reset clears the frame to zero
// and empties the FIFO; the result side never stalls.
module can_signal_extract_insert import cse_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  cmd,
  output logic done,
  output out_t result
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;

  assign busy = q_full;
  assign push = start && !q_full;
  assign pop  = !q_empty;

  cse_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .item (cmd),
    .cmd  (front_cmd)
  );

  cse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .pop_data  (head_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  cse_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk    (clk),
    .rst    (rst),
    .valid  (pop),
    .cmd    (head_cmd),
    .done   (done),
    .result (result)
  );

endmodule
